@@ rtl/thumbit_pkg.sv @@
// ============================================================================
// Thumb register file / IT unit package
// Shared operation codes, field widths and condition helpers.
// ============================================================================
package thumbit_pkg;

    localparam int unsigned OpW       = 3;
    localparam int unsigned RegIdxW   = 4;
    localparam int unsigned DataW     = 32;
    localparam int unsigned FlagIdxW  = 3;
    localparam int unsigned NumFlags  = 5;
    localparam int unsigned ItW       = 8;
    localparam int unsigned NumRegs   = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int unsigned InFieldsW  = OpW + RegIdxW + DataW + DataW + FlagIdxW;
    localparam int unsigned InTdataW   = ((InFieldsW + 7) / 8) * 8;
    localparam int unsigned OutFieldsW = DataW + 4;
    localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

    // Operation codes.
    localparam logic [OpW-1:0] OP_READ_REG  = 3'd0;
    localparam logic [OpW-1:0] OP_WRITE_REG = 3'd1;
    localparam logic [OpW-1:0] OP_ADD_PC    = 3'd2;
    localparam logic [OpW-1:0] OP_SET_FLAG  = 3'd3;
    localparam logic [OpW-1:0] OP_LOAD_IT   = 3'd4;
    localparam logic [OpW-1:0] OP_ADV_IT    = 3'd5;
    localparam logic [OpW-1:0] OP_CLR_MARK  = 3'd6;

    // Flag selectors on the input and bit positions in the flag word.
    localparam logic [FlagIdxW-1:0] FSEL_N = 3'd0;
    localparam logic [FlagIdxW-1:0] FSEL_Z = 3'd1;
    localparam logic [FlagIdxW-1:0] FSEL_C = 3'd2;
    localparam logic [FlagIdxW-1:0] FSEL_V = 3'd3;
    localparam logic [FlagIdxW-1:0] FSEL_Q = 3'd4;

    localparam int unsigned FLAG_N = 4;
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_C = 2;
    localparam int unsigned FLAG_V = 1;
    localparam int unsigned FLAG_Q = 0;

    localparam logic [3:0] COND_AL = 4'd14;
    localparam logic [3:0] COND_NV = 4'd15;
    localparam logic [RegIdxW-1:0] PC_REG = 4'd15;

    typedef logic [NumFlags-1:0] flags_t;
    typedef logic [ItW-1:0]      it_t;

    // Condition in effect: the upper IT bits inside a block, AL outside.
    function automatic logic cond_pass(input it_t it, input flags_t fl);
        logic [3:0] cond;
        logic       n;
        logic       z;
        logic       c;
        logic       v;
        logic       r;
        cond = (it[3:0] != 4'd0) ? it[7:4] : COND_AL;
        n = fl[FLAG_N];
        z = fl[FLAG_Z];
        c = fl[FLAG_C];
        v = fl[FLAG_V];
        case (cond[3:1])
            3'd0:    r = z;
            3'd1:    r = c;
            3'd2:    r = n;
            3'd3:    r = v;
            3'd4:    r = c & ~z;
            3'd5:    r = (n == v);
            3'd6:    r = (n == v) & ~z;
            default: r = 1'b1;
        endcase
        if (cond[0] && (cond != COND_NV))
        begin
            r = ~r;
        end
        return r;
    endfunction

    // Advance the IT state by one instruction.
    function automatic it_t it_advance(input it_t it);
        it_t nxt;
        if (it[2:0] == 3'd0)
        begin
            nxt = '0;
        end
        else
        begin
            nxt = {it[7:5], it[3:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

@@ rtl/thumb_regfile_it_condition_unit.sv @@
// ============================================================================
// Thumb register file with IT-block and condition unit
// Sixteen core registers in a synchronous memory, flags, IT state and the
// PC-written mark, one operation per item.
// ============================================================================
// Usage:
// Items enter on the s_axis channel; each carries one operation (register
// read or write, PC add, flag set, IT load or advance, mark clear). Every
// item yields exactly one result item on the m_axis channel with the read
// data and the condition status taken after the operation.
// The core registers live in a 16 x 32 memory with a registered read port.
// An accepted item reads its register in the cycle it is taken (register 15
// for a PC add); the update stage then updates the state, writes the memory
// back and loads the output register once that register is free. The next
// item is only taken once the write-back is done, so memory accesses never
// overlap.
// Reset clears the flags, IT state, mark and the per-register valid bits at
// once; a register that was never written reads as zero, so no clearing
// pass is needed and an item can be taken right after reset.
// When the receiver stalls, the result waits in the output register; one
// further item can still be taken and read, and it then holds in the
// update stage until the output register frees up.
// ============================================================================
module thumb_regfile_it_condition_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0 up: op[2:0], reg_index[6:3], value[38:7],
    // pc_delta[70:39], flag_index[73:71], zero pad.
    input  logic [thumbit_pkg::InTdataW-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0 up: read_data[31:0], cond_pass[32], in_it_block[33],
    // last_in_it[34], pc_written[35], zero pad.
    output logic [thumbit_pkg::OutTdataW-1:0]     m_axis_tdata
);

    localparam int unsigned DW = thumbit_pkg::DataW;
    localparam int unsigned AW = thumbit_pkg::RegIdxW;

    // Unpacked input fields.
    logic [thumbit_pkg::OpW-1:0]      in_op;
    logic [AW-1:0]                    in_reg;
    logic [DW-1:0]                    in_value;
    logic signed [DW-1:0]             in_delta;
    logic [thumbit_pkg::FlagIdxW-1:0] in_fidx;

    assign in_op    = s_axis_tdata[2:0];
    assign in_reg   = s_axis_tdata[6:3];
    assign in_value = s_axis_tdata[38:7];
    assign in_delta = s_axis_tdata[70:39];
    assign in_fidx  = s_axis_tdata[73:71];

    // Register memory with one write and one registered read port.
    logic [DW-1:0] regs_mem [thumbit_pkg::NumRegs];
    logic [DW-1:0] rd_q_reg;
    logic [thumbit_pkg::NumRegs-1:0] vld_reg;
    logic [thumbit_pkg::NumRegs-1:0] vld_next;
    logic          rd_vld_reg;

    // Update-stage item and control.
    logic                             busy_reg;
    logic                             busy_next;
    logic [thumbit_pkg::OpW-1:0]      op_reg;
    logic [AW-1:0]                    reg_idx_reg;
    logic [DW-1:0]                    value_reg;
    logic [DW-1:0]                    delta_reg;
    logic [thumbit_pkg::FlagIdxW-1:0] fidx_reg;

    // Architectural state outside the memory.
    thumbit_pkg::flags_t flags_reg;
    thumbit_pkg::flags_t flags_next;
    thumbit_pkg::it_t    it_reg;
    thumbit_pkg::it_t    it_next;
    logic                mark_reg;
    logic                mark_next;

    // Output register.
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [DW+3:0]         out_data_reg;
    logic [DW+3:0]         out_data_next;

    logic          s_fire;
    logic          upd_fire;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] old_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] rdata;

    assign s_axis_tready = ~busy_reg;
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign upd_fire      = busy_reg & (~out_vld_reg | m_axis_tready);

    // A PC add reads register 15; everything else reads its own index.
    assign rd_addr  = (in_op == thumbit_pkg::OP_ADD_PC) ? thumbit_pkg::PC_REG : in_reg;
    assign old_data = rd_vld_reg ? rd_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            regs_mem[wr_addr] <= wr_data;
        end
        if (s_fire)
        begin
            rd_q_reg <= regs_mem[rd_addr];
        end
    end

    // Payload capture; no reset needed.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg      <= in_op;
            reg_idx_reg <= in_reg;
            value_reg   <= in_value;
            delta_reg   <= in_delta;
            fidx_reg    <= in_fidx;
        end
        if (upd_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Update stage: one operation on the state, one memory write at most.
    always_comb
    begin
        flags_next = flags_reg;
        it_next    = it_reg;
        mark_next  = mark_reg;
        vld_next   = vld_reg;
        wr_en      = 1'b0;
        wr_addr    = reg_idx_reg;
        wr_data    = value_reg;
        rdata      = '0;
        unique case (op_reg)
            thumbit_pkg::OP_READ_REG:
            begin
                rdata = old_data;
            end
            thumbit_pkg::OP_WRITE_REG:
            begin
                wr_en = upd_fire;
                if (reg_idx_reg == thumbit_pkg::PC_REG)
                begin
                    mark_next = 1'b1;
                end
            end
            thumbit_pkg::OP_ADD_PC:
            begin
                wr_en   = upd_fire;
                wr_addr = thumbit_pkg::PC_REG;
                wr_data = old_data + delta_reg;
            end
            thumbit_pkg::OP_SET_FLAG:
            begin
                case (fidx_reg)
                    thumbit_pkg::FSEL_N: flags_next[thumbit_pkg::FLAG_N] = value_reg[0];
                    thumbit_pkg::FSEL_Z: flags_next[thumbit_pkg::FLAG_Z] = value_reg[0];
                    thumbit_pkg::FSEL_C: flags_next[thumbit_pkg::FLAG_C] = value_reg[0];
                    thumbit_pkg::FSEL_V: flags_next[thumbit_pkg::FLAG_V] = value_reg[0];
                    thumbit_pkg::FSEL_Q: flags_next[thumbit_pkg::FLAG_Q] = value_reg[0];
                    default:             flags_next = flags_reg;
                endcase
            end
            thumbit_pkg::OP_LOAD_IT:
            begin
                it_next = value_reg[thumbit_pkg::ItW-1:0];
            end
            thumbit_pkg::OP_ADV_IT:
            begin
                it_next = thumbit_pkg::it_advance(it_reg);
            end
            thumbit_pkg::OP_CLR_MARK:
            begin
                mark_next = 1'b0;
            end
            default:
            begin
                rdata = '0;
            end
        endcase
        if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
        out_data_next = {mark_next,
                         (it_next[3:0] == 4'd8),
                         (it_next[3:0] != 4'd0),
                         thumbit_pkg::cond_pass(it_next, flags_next),
                         rdata};
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (s_fire)
        begin
            busy_next = 1'b1;
        end
        else if (upd_fire)
        begin
            busy_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (upd_fire)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            flags_reg   <= '0;
            it_reg      <= '0;
            mark_reg    <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            out_vld_reg <= out_vld_next;
            if (s_fire)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (upd_fire)
            begin
                vld_reg   <= vld_next;
                flags_reg <= flags_next;
                it_reg    <= it_next;
                mark_reg  <= mark_next;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(thumbit_pkg::OutTdataW - (DW + 4)){1'b0}}, out_data_reg};

    // An item taken in always reaches the update stage next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> busy_reg)
        else $error("accepted item did not enter the update stage");

    // A stalled output must keep the waiting item in the update stage.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_vld_reg && !m_axis_tready |=> busy_reg)
        else $error("item dropped while the output was stalled");

    // A new result only appears after the update stage held an item.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(busy_reg))
        else $error("result produced without an item in the update stage");

    // The last instruction of an IT block is always inside the block.
    a_last_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_data_reg[DW+2] |-> out_data_reg[DW+1])
        else $error("last_in_it set outside an IT block");

endmodule
